// ===== hdl/char_lcd_shadow_refresh_core_macros.svh =====
// Assertion macros shared by the character LCD refresh block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CHAR_LCD_SHADOW_REFRESH_CORE_MACROS_SVH
`define CHAR_LCD_SHADOW_REFRESH_CORE_MACROS_SVH

// Check cons in the same cycle as ante
`define CLSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante
`define CLSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/clsr_pkg.sv =====
// Types, codes and helpers for the character LCD shadow refresh block.
// No dependencies.
package clsr_pkg;

	localparam logic [1:0] ACT_PUT     = 2'd0;
	localparam logic [1:0] ACT_CLEAR   = 2'd1;
	localparam logic [1:0] ACT_REFRESH = 2'd2;

	localparam logic [1:0] REG_CURSOR_VISIBLE = 2'd0;
	localparam logic [1:0] REG_CURSOR_BLINK   = 2'd1;
	localparam logic [1:0] REG_SCROLL_ENABLE  = 2'd2;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [5:0] CLEAR_MARGIN = 6'd10;
	localparam logic [4:0] LINE_TWO     = 5'd16;

	localparam int PLAN_DEPTH = 6;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCROLL = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_PLAN   = 5'b01000,
		ST_EMIT   = 5'b10000
	} clsr_state_t;

	// DDRAM address command: line two starts at controller address 0x40
	function automatic logic [7:0] ddram_move(input logic [4:0] a);
		return {1'b1, a[4], 2'b00, a[3:0]};
	endfunction

	// Display on, cursor and blink flags
	function automatic logic [7:0] display_ctrl(input logic vis, input logic blink);
		return {4'b0000, 1'b1, 1'b1, vis, blink};
	endfunction

endpackage

// ===== hdl/char_lcd_shadow_refresh_core.sv =====
// Put and clear complete when accepted; a put that wraps or a newline on line two scrolls
// when scroll is enabled. Refresh: a sweep over both text memories, a planning state,
// then one bus beat per cycle (up to 6) while the output does not stall; a refresh holds
// the input throughout. The sweep rate is set by the single read port of each
// 32-entry memory. One item is processed at a time.
// Reset clears all control state; per-entry valid bits make both stores read as
// spaces at once, so there is no clearing pass.
`include "char_lcd_shadow_refresh_core_macros.svh"

module char_lcd_shadow_refresh_core
	import clsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_data,
	output logic [7:0] bus_byte,
	output logic       last,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [0:0] cfg_data
);

	clsr_state_t state_q;
	logic [5:0]  cnt_q;
	logic [4:0]  wp_q, sp_q;
	logic        cv_q, cb_q, se_q;
	logic        scf_q, sbf_q;
	logic [31:0] wv_q, sv_q;

	// Text memories and their read stage
	logic [7:0]  wmem [0:31];
	logic [7:0]  smem [0:31];
	logic [7:0]  wrd_s1, srd_s1;
	logic        wv_s1, sv_s1, rd_s1;
	logic [4:0]  addr_s1;

	// Sweep results
	logic [5:0]  ns_q, df_q;
	logic        nfound_q, dfound_q;
	logic [4:0]  nidx_q, didx_q;
	logic [7:0]  nbyte_q, dbyte_q;

	// Beat plan
	logic [7:0]  pbyte_q [0:PLAN_DEPTH-1];
	logic        pdat_q  [0:PLAN_DEPTH-1];
	logic [2:0]  pn_q, ecnt_q;

	logic        ovalid_q, odat_q, olast_q;
	logic [7:0]  obyte_q;

	logic        in_acc;
	logic        emit_go;
	logic        w_we, s_we;
	logic [4:0]  w_addr, w_raddr;
	logic [7:0]  w_data, w_eff, s_eff;
	logic [4:0]  wp_inc;

	logic        clr, has_cell;
	logic [5:0]  eff_diff;
	logic [4:0]  cidx;
	logic [7:0]  cbyte;
	logic [7:0]  pb [0:PLAN_DEPTH-1];
	logic        pd [0:PLAN_DEPTH-1];
	logic [2:0]  pn;
	logic [4:0]  psp;
	logic [31:0] wv_d, sv_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign emit_go   = (state_q == ST_EMIT) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign is_data   = odat_q;
	assign bus_byte  = obyte_q;
	assign last      = olast_q;

	assign w_eff   = wv_s1 ? wrd_s1 : CHAR_SPACE;
	assign s_eff   = sv_s1 ? srd_s1 : CHAR_SPACE;
	assign wp_inc  = wp_q + 5'd1;
	assign w_raddr = (state_q == ST_SCROLL) ? {1'b1, cnt_q[3:0]} : cnt_q[4:0];

	// Wanted store write port: put in idle, line move during scroll
	always_comb begin
		w_we   = 1'b0;
		w_addr = wp_q;
		w_data = char_code;
		if (in_acc && action == ACT_PUT && char_code != CHAR_NEWLINE) begin
			w_we = 1'b1;
		end else if (state_q == ST_SCROLL && rd_s1) begin
			w_we   = 1'b1;
			w_addr = {1'b0, addr_s1[3:0]};
			w_data = w_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_addr] <= w_data;
		end
		wrd_s1 <= wmem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[cidx] <= cbyte;
		end
		srd_s1 <= smem[cnt_q[4:0]];
	end

	// Pick the clear decision and the cell to repair
	always_comb begin
		clr      = (CLEAR_MARGIN + ns_q) < df_q;
		eff_diff = clr ? ns_q : df_q;
		has_cell = clr ? nfound_q : dfound_q;
		cidx     = clr ? nidx_q : didx_q;
		cbyte    = clr ? nbyte_q : dbyte_q;
		s_we     = (state_q == ST_PLAN) && has_cell;
	end

	// Build the beat plan for this refresh
	always_comb begin
		pb  = '{default: 8'h00};
		pd  = '{default: 1'b0};
		pn  = 3'd0;
		psp = sp_q;
		if (clr) begin
			pb[pn] = CMD_CLEAR;
			pn     = pn + 3'd1;
			psp    = 5'd0;
		end
		if (has_cell) begin
			if (cidx != psp) begin
				pb[pn] = ddram_move(cidx);
				pn     = pn + 3'd1;
			end
			pb[pn] = cbyte;
			pd[pn] = 1'b1;
			pn     = pn + 3'd1;
			psp    = cidx + 5'd1;
			if (psp[3:0] == 4'd0) begin
				pb[pn] = ddram_move(psp);
				pn     = pn + 3'd1;
			end
		end
		if (cv_q != scf_q || cb_q != sbf_q) begin
			pb[pn] = display_ctrl(cv_q, cb_q);
			pn     = pn + 3'd1;
		end
		if (cv_q && wp_q != psp && eff_diff <= 6'd1) begin
			pb[pn] = ddram_move(wp_q);
			pn     = pn + 3'd1;
			psp    = wp_q;
		end
	end

	// Valid bits: unset entries read as spaces
	always_comb begin
		wv_d = wv_q;
		sv_d = sv_q;
		if (w_we) begin
			wv_d[w_addr] = 1'b1;
		end
		if (in_acc && action == ACT_CLEAR) begin
			wv_d = '0;
		end
		if (state_q == ST_SCROLL && cnt_q == 6'd16) begin
			wv_d[31:16] = '0;
		end
		if (state_q == ST_PLAN) begin
			if (clr) begin
				sv_d = '0;
			end
			if (has_cell) begin
				sv_d[cidx] = 1'b1;
			end
		end
	end

	// Control, sweep and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			wp_q     <= '0;
			sp_q     <= '0;
			cv_q     <= 1'b0;
			cb_q     <= 1'b0;
			se_q     <= 1'b1;
			scf_q    <= 1'b0;
			sbf_q    <= 1'b0;
			wv_q     <= '0;
			sv_q     <= '0;
			wv_s1    <= 1'b0;
			sv_s1    <= 1'b0;
			rd_s1    <= 1'b0;
			addr_s1  <= '0;
			ns_q     <= '0;
			df_q     <= '0;
			nfound_q <= 1'b0;
			dfound_q <= 1'b0;
			nidx_q   <= '0;
			didx_q   <= '0;
			nbyte_q  <= '0;
			dbyte_q  <= '0;
			pn_q     <= '0;
			ecnt_q   <= '0;
			ovalid_q <= 1'b0;
			odat_q   <= 1'b0;
			olast_q  <= 1'b0;
			obyte_q  <= '0;
		end else begin
			wv_q    <= wv_d;
			sv_q    <= sv_d;
			wv_s1   <= wv_q[w_raddr];
			sv_s1   <= sv_q[cnt_q[4:0]];
			addr_s1 <= cnt_q[4:0];
			rd_s1   <= (state_q == ST_SCAN && cnt_q < 6'd32) ||
				(state_q == ST_SCROLL && cnt_q < 6'd16);

			// Configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CURSOR_VISIBLE: cv_q <= cfg_data[0];
					REG_CURSOR_BLINK:   cb_q <= cfg_data[0];
					REG_SCROLL_ENABLE:  se_q <= cfg_data[0];
					default: ;
				endcase
			end

			// Raise the output beat when one is loaded, drop it once taken
			if (emit_go) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						unique case (action)
							ACT_PUT: begin
								if (char_code == CHAR_NEWLINE) begin
									wp_q <= LINE_TWO;
									if (wp_q[4] && se_q) begin
										state_q <= ST_SCROLL;
									end
								end else if (wp_inc == 5'd0 && se_q) begin
									wp_q    <= LINE_TWO;
									state_q <= ST_SCROLL;
								end else begin
									wp_q <= wp_inc;
								end
							end
							ACT_CLEAR: begin
								wp_q <= '0;
							end
							ACT_REFRESH: begin
								ns_q     <= '0;
								df_q     <= '0;
								nfound_q <= 1'b0;
								dfound_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCROLL: begin
					// Copy line two up one entry a cycle, then blank it
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd16) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// Count non-space cells and differences over all cells, and locate the first of each
					cnt_q <= cnt_q + 6'd1;
					if (rd_s1) begin
						if (w_eff != CHAR_SPACE) begin
							ns_q <= ns_q + 6'd1;
							if (!nfound_q) begin
								nfound_q <= 1'b1;
								nidx_q   <= addr_s1;
								nbyte_q  <= w_eff;
							end
						end
						if (w_eff != s_eff) begin
							df_q <= df_q + 6'd1;
							if (!dfound_q) begin
								dfound_q <= 1'b1;
								didx_q   <= addr_s1;
								dbyte_q  <= w_eff;
							end
						end
					end
					if (cnt_q == 6'd32) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					sp_q   <= psp;
					scf_q  <= cv_q;
					sbf_q  <= cb_q;
					pn_q   <= pn;
					ecnt_q <= '0;
					state_q <= (pn == 3'd0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					// Advance one beat whenever the output register is free
					if (emit_go) begin
						odat_q   <= pdat_q[ecnt_q];
						obyte_q  <= pbyte_q[ecnt_q];
						olast_q  <= (ecnt_q == pn_q - 3'd1);
						ecnt_q   <= ecnt_q + 3'd1;
						if (ecnt_q == pn_q - 3'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the planned beats
	always_ff @(posedge clk) begin
		if (state_q == ST_PLAN) begin
			pbyte_q <= pb;
			pdat_q  <= pd;
		end
	end

	`CLSR_ASSERT_NEXT(a_beat_only_from_emit, (state_q != ST_EMIT) && !ovalid_q, !ovalid_q, "output beat raised outside emit")
	`CLSR_ASSERT_NOW(a_plan_bounds, state_q == ST_EMIT, (pn_q != 3'd0) && (pn_q <= 3'd6) && (ecnt_q < pn_q), "beat plan out of range")
	`CLSR_ASSERT_NOW(a_scroll_pos, state_q == ST_SCROLL, wp_q == LINE_TWO, "write position not on line two during scroll")
	`CLSR_ASSERT_NEXT(a_scan_to_plan, (state_q == ST_SCAN) && (cnt_q == 6'd32), state_q == ST_PLAN, "sweep did not end in planning")

endmodule
